FILE: hw/rtl/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM     = 4;
  localparam int ELEMS   = DIM * DIM;
  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int IDX_W   = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam idx_t  IDX_LAST = idx_t'(ELEMS - 1);

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } state_t;

  // travels alongside the datapath stages
  typedef struct packed {
    logic valid;
    idx_t idx;
  } ctrl_t;

endpackage

FILE: hw/rtl/mm4_lane.sv
module mm4_lane (
  input  logic           clk,
  input  logic           en,
  input  mm4_pkg::elem_t a,
  input  mm4_pkg::elem_t b,
  output mm4_pkg::prod_t product
);

  // full signed 32x32 product, registered
  always_ff @(posedge clk) begin
    if (en) begin
      product <= mm4_pkg::prod_t'(a) * mm4_pkg::prod_t'(b);
    end
  end

endmodule

FILE: hw/rtl/mm4_merge.sv
module mm4_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  mm4_pkg::ctrl_t ctrl_in,
  input  mm4_pkg::prod_t lane_product [mm4_pkg::DIM],
  output logic           out_valid,
  output mm4_pkg::elem_t product_element,
  output mm4_pkg::idx_t  element_index,
  output logic           last
);

  mm4_pkg::sum_t  sum;
  mm4_pkg::ctrl_t ctrl_sum;
  mm4_pkg::sum_t  shifted;
  mm4_pkg::elem_t sat;
  logic [mm4_pkg::SUM_W-mm4_pkg::ELEM_W:0] upper;

  // stage 1: exact four-term sum
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= mm4_pkg::sum_t'(lane_product[0]) + mm4_pkg::sum_t'(lane_product[1])
           + mm4_pkg::sum_t'(lane_product[2]) + mm4_pkg::sum_t'(lane_product[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_sum <= '0;
    end else if (en) begin
      ctrl_sum <= ctrl_in;
    end
  end

  // arithmetic shift rounds toward minus infinity, then clamp
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    upper   = shifted[mm4_pkg::SUM_W-1:mm4_pkg::ELEM_W-1];
    if (~|upper || &upper) begin
      sat = shifted[mm4_pkg::ELEM_W-1:0];
    end else if (sum[mm4_pkg::SUM_W-1]) begin
      sat = mm4_pkg::ELEM_MIN;
    end else begin
      sat = mm4_pkg::ELEM_MAX;
    end
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl_sum.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product_element <= sat;
      element_index   <= ctrl_sum.idx;
      last            <= (ctrl_sum.idx == mm4_pkg::IDX_LAST);
    end
  end

endmodule

FILE: hw/rtl/matrix_multiply_4x4.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_ready  | a_element, b_element (signed Q16.16)
// output   | out_valid / out_ready| product_element, element_index, last
//
// sixteen input transfers fill both matrices, one cycle each at best
// then sixteen issue cycles, one product element each: four multiplier
// lanes take one term each and the merge stage sums, shifts and saturates
// reset returns to loading with a zero count; element stores stay unset
// a stalled output freezes the whole lane pipeline; no input during issue
module matrix_multiply_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  a_element,
  input  logic signed [31:0]  b_element,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  product_element,
  output logic        [3:0]   element_index,
  output logic                last
);

  mm4_pkg::state_t state, state_next;
  mm4_pkg::idx_t   load_cnt;
  mm4_pkg::idx_t   issue_cnt;
  mm4_pkg::elem_t  left_store  [mm4_pkg::ELEMS];
  mm4_pkg::elem_t  right_store [mm4_pkg::ELEMS];
  mm4_pkg::ctrl_t  ctrl_lane;
  mm4_pkg::prod_t  lane_product [mm4_pkg::DIM];

  logic adv;
  logic load;
  logic issue;

  // whole pipeline moves when the output register is free or drained
  assign adv   = !out_valid || out_ready;
  assign load  = in_valid && in_ready;
  assign issue = (state == mm4_pkg::ST_RUN) && adv;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm4_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      mm4_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (load && load_cnt == mm4_pkg::IDX_LAST) begin
          state_next = mm4_pkg::ST_RUN;
        end
      end
      mm4_pkg::ST_RUN: begin
        if (issue && issue_cnt == mm4_pkg::IDX_LAST) begin
          state_next = mm4_pkg::ST_LOAD;
        end
      end
      default: state_next = mm4_pkg::ST_LOAD;
    endcase
  end

  // pair count and issue position
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt  <= '0;
      issue_cnt <= '0;
    end else begin
      if (load) begin
        load_cnt <= load_cnt + 1'b1;
      end
      if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  // element stores: written in row-major order while loading
  // while issuing, left moves up one row after each row of results so
  // lane k always sees a[r][k] at entry k; right rotates each row by one
  // column per unstalled cycle so lane k sees b[k][c] at the head of row k
  always_ff @(posedge clk) begin
    for (int i = 0; i < mm4_pkg::ELEMS; i++) begin
      if (load && load_cnt == mm4_pkg::idx_t'(i)) begin
        left_store[i]  <= a_element;
        right_store[i] <= b_element;
      end else if (issue) begin
        if (issue_cnt[1:0] == 2'd3) begin
          left_store[i] <= left_store[(i + mm4_pkg::DIM) % mm4_pkg::ELEMS];
        end
        right_store[i] <= right_store[(i / mm4_pkg::DIM) * mm4_pkg::DIM
                                      + ((i + 1) % mm4_pkg::DIM)];
      end
    end
  end

  // control beside the lane products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_lane <= '0;
    end else if (adv) begin
      ctrl_lane.valid <= issue;
      ctrl_lane.idx   <= issue_cnt;
    end
  end

  // one multiplier lane per inner-product term
  for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_lane
    mm4_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .a       (left_store[k]),
      .b       (right_store[k * mm4_pkg::DIM]),
      .product (lane_product[k])
    );
  end

  // sum of lanes, shift and saturate, output register
  mm4_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .en              (adv),
    .ctrl_in         (ctrl_lane),
    .lane_product    (lane_product),
    .out_valid       (out_valid),
    .product_element (product_element),
    .element_index   (element_index),
    .last            (last)
  );

  // sixteenth transfer starts issue from the first element
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    load && load_cnt == mm4_pkg::IDX_LAST |=> state == mm4_pkg::ST_RUN && issue_cnt == '0)
    else $error("issue did not start after the sixteenth transfer");

  // last issue hands control back to loading
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    issue && issue_cnt == mm4_pkg::IDX_LAST |=> state == mm4_pkg::ST_LOAD && load_cnt == '0)
    else $error("loading did not resume after the final element");

  // last marks exactly the final element
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (element_index == mm4_pkg::IDX_LAST)))
    else $error("last does not match element index");

endmodule
